/* rtl/bdlp_pkg.sv */
// Shared types, constants and width helpers for the button debouncer.
// No dependencies; used by every other file of the block.

package bdlp_pkg;

    localparam int BUTTON_COUNT_DEF = 5;
    localparam int TIME_W           = 32;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int UP_IDX           = 0;
    localparam int DOWN_IDX         = 1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] COMBO_RST    = 16'd3000;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBO    = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] combo_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic              short_evt;
        logic              long_evt;
        logic              pressed;
        logic [TIME_W-1:0] hold_ms;
    } btn_status_t;

    function automatic int ev_width(input int n);
        return $clog2(2 * n + 1);
    endfunction

    function automatic int byte_round(input int w);
        return ((w + 7) >> 3) << 3;
    endfunction

    function automatic int in_raw_width(input int n);
        return TIME_W + n + 1;
    endfunction

    function automatic int out_raw_width(input int n);
        return ev_width(n) + n + 1 + 1 + TIME_W + 1;
    endfunction

endpackage

/* rtl/bdlp_button.sv */
// One button cell: raw change time, debounced level, press start and long flag.
// Depends on bdlp_pkg.

module bdlp_button (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic [bdlp_pkg::TIME_W-1:0]  now_ms,
    input  logic                         raw_bit,
    input  bdlp_pkg::cfg_t               cfg,
    output bdlp_pkg::btn_status_t        status
);

    logic                        prev_reg, prev_next;
    logic                        stable_reg, stable_next;
    logic                        long_done_reg, long_done_next;
    logic [bdlp_pkg::TIME_W-1:0] change_time_reg, change_time_next;
    logic [bdlp_pkg::TIME_W-1:0] press_start_reg, press_start_next;

    logic                        deb_pass;
    logic                        lvl_edge;
    logic                        press;
    logic                        release_evt;
    logic                        long_mid;
    logic                        long_ok;
    logic                        long_evt;
    logic [bdlp_pkg::TIME_W-1:0] held_diff;
    logic [bdlp_pkg::TIME_W-1:0] long_thr;
    logic [bdlp_pkg::TIME_W-1:0] deb_thr;

    always_comb begin
        long_thr         = {{(bdlp_pkg::TIME_W-bdlp_pkg::CFG_W){1'b0}}, cfg.long_press_ms};
        deb_thr          = {{(bdlp_pkg::TIME_W-bdlp_pkg::CFG_W){1'b0}}, cfg.debounce_ms};
        prev_next        = raw_bit;
        change_time_next = (raw_bit != prev_reg) ? now_ms : change_time_reg;
        deb_pass         = (now_ms - change_time_next) > deb_thr;
        lvl_edge         = deb_pass && (raw_bit != stable_reg);
        stable_next      = lvl_edge ? raw_bit : stable_reg;
        press            = lvl_edge && !raw_bit;
        release_evt      = lvl_edge && raw_bit;
        if (press) begin
            press_start_next = now_ms;
        end else if (release_evt) begin
            press_start_next = '0;
        end else begin
            press_start_next = press_start_reg;
        end
        long_mid   = press ? 1'b0 : long_done_reg;
        held_diff  = now_ms - press_start_reg;
        long_ok    = press ? (cfg.long_press_ms == '0) : (held_diff >= long_thr);
        long_evt   = deb_pass && !stable_next && !long_mid
                     && (press_start_next != '0) && long_ok;
        long_done_next = long_mid | long_evt;

        status.short_evt = release_evt && !long_done_reg;
        status.long_evt  = long_evt;
        status.pressed   = !stable_next;
        status.hold_ms   = (!stable_next && (press_start_next != '0) && !press)
                           ? held_diff : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg        <= 1'b1;
            stable_reg      <= 1'b1;
            long_done_reg   <= 1'b0;
            change_time_reg <= '0;
            press_start_reg <= '0;
        end else if (adv) begin
            prev_reg        <= prev_next;
            stable_reg      <= stable_next;
            long_done_reg   <= long_done_next;
            change_time_reg <= change_time_next;
            press_start_reg <= press_start_next;
        end
    end

endmodule

/* rtl/bdlp_combo.sv */
// Up+down combo tracker: start time, done flag and the one-shot fire.
// Depends on bdlp_pkg.

module bdlp_combo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic [bdlp_pkg::TIME_W-1:0]  now_ms,
    input  logic                         both_held,
    input  logic                         clear_combo,
    input  logic [bdlp_pkg::CFG_W-1:0]   combo_hold_ms,
    output logic                         combo_fired
);

    logic [bdlp_pkg::TIME_W-1:0] start_reg, start_next;
    logic                        done_reg, done_next;
    logic [bdlp_pkg::TIME_W-1:0] start_eff;
    logic                        done_eff;
    logic                        reach;

    always_comb begin
        start_eff = clear_combo ? '0 : start_reg;
        done_eff  = clear_combo ? 1'b0 : done_reg;
        reach     = (start_eff == '0)
                    ? (combo_hold_ms == '0)
                    : ((now_ms - start_eff) >=
                       {{(bdlp_pkg::TIME_W-bdlp_pkg::CFG_W){1'b0}}, combo_hold_ms});
        if (both_held) begin
            start_next  = (start_eff == '0) ? now_ms : start_eff;
            combo_fired = !done_eff && reach;
            done_next   = done_eff | combo_fired;
        end else begin
            start_next  = '0;
            combo_fired = 1'b0;
            done_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            done_reg  <= 1'b0;
        end else if (adv) begin
            start_reg <= start_next;
            done_reg  <= done_next;
        end
    end

endmodule

/* rtl/button_debounce_long_press.sv */
// A poll word accepted on the input is held in the input register until it can move
// on into the result register, from which the result side takes it.
// Throughput: one poll word per cycle; the input stalls only while both the input
// and result registers hold a word and the result side is not ready.
// Reset (aresetn low, synchronous): both registers empty, debounce state idle,
// configuration back to 50 / 1000 / 3000 ms.
// Depends on bdlp_pkg, bdlp_button, bdlp_combo.

module button_debounce_long_press #(
    parameter int BUTTON_COUNT = bdlp_pkg::BUTTON_COUNT_DEF,
    localparam int IN_W  = bdlp_pkg::byte_round(bdlp_pkg::in_raw_width(BUTTON_COUNT)),
    localparam int OUT_W = bdlp_pkg::byte_round(bdlp_pkg::out_raw_width(BUTTON_COUNT))
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // now_ms[31:0], raw_levels[BUTTON_COUNT], clear_combo
    input  logic [IN_W-1:0]                s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // event_code, pressed_mask, any_pressed, select_held, select_hold_ms, combo_fired
    output logic [OUT_W-1:0]               m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdlp_pkg::CFG_W-1:0]     cfg_data
);

    localparam int TW       = bdlp_pkg::TIME_W;
    localparam int EV_W     = bdlp_pkg::ev_width(BUTTON_COUNT);
    localparam int IN_RAW_W = bdlp_pkg::in_raw_width(BUTTON_COUNT);
    localparam int SEL_IDX  = BUTTON_COUNT - 1;

    bdlp_pkg::cfg_t        cfg_reg;
    logic                  in_valid_reg, in_valid_next;
    logic [IN_RAW_W-1:0]   in_data_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [EV_W-1:0]       event_reg, event_next;
    logic [BUTTON_COUNT-1:0] pressed_reg, pressed_next;
    logic [TW-1:0]         hold_reg;
    logic                  fired_reg, fired_next;
    logic                  adv;

    logic [TW-1:0]           now_ms;
    logic [BUTTON_COUNT-1:0] raw_levels;
    logic                    clear_combo;
    bdlp_pkg::btn_status_t   status [BUTTON_COUNT];

    assign cfg_ready     = 1'b1;
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign now_ms        = in_data_reg[TW-1:0];
    assign raw_levels    = in_data_reg[TW +: BUTTON_COUNT];
    assign clear_combo   = in_data_reg[TW + BUTTON_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms   <= bdlp_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ms <= bdlp_pkg::LONG_RST;
            cfg_reg.combo_hold_ms <= bdlp_pkg::COMBO_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                bdlp_pkg::CFG_DEBOUNCE: cfg_reg.debounce_ms   <= cfg_data;
                bdlp_pkg::CFG_LONG:     cfg_reg.long_press_ms <= cfg_data;
                bdlp_pkg::CFG_COMBO:    cfg_reg.combo_hold_ms <= cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
        bdlp_button u_btn (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .now_ms  (now_ms),
            .raw_bit (raw_levels[i]),
            .cfg     (cfg_reg),
            .status  (status[i])
        );
    end

    bdlp_combo u_combo (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .now_ms        (now_ms),
        .both_held     (pressed_next[bdlp_pkg::UP_IDX] && pressed_next[bdlp_pkg::DOWN_IDX]),
        .clear_combo   (clear_combo),
        .combo_hold_ms (cfg_reg.combo_hold_ms),
        .combo_fired   (fired_next)
    );

    always_comb begin
        event_next = '0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            pressed_next[i] = status[i].pressed;
            if (status[i].long_evt) begin
                event_next = EV_W'(BUTTON_COUNT + i + 1);
            end else if (status[i].short_evt) begin
                event_next = EV_W'(i + 1);
            end
        end
    end

    always_comb begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (adv) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_data_reg <= s_axis_tdata[IN_RAW_W-1:0];
        end
        if (adv) begin
            event_reg   <= event_next;
            pressed_reg <= pressed_next;
            hold_reg    <= status[SEL_IDX].hold_ms;
            fired_reg   <= fired_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({fired_reg, hold_reg, pressed_reg[SEL_IDX],
                                   |pressed_reg, pressed_reg, event_reg});

endmodule

/* rtl/bdlp_checker.sv */
// Port-level checker for the button debouncer, bound to the top level.
// Depends on bdlp_pkg and button_debounce_long_press.

module bdlp_port_checker #(
    parameter int BUTTON_COUNT = bdlp_pkg::BUTTON_COUNT_DEF,
    localparam int OUT_W = bdlp_pkg::byte_round(bdlp_pkg::out_raw_width(BUTTON_COUNT))
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [OUT_W-1:0]               m_axis_tdata
);

    localparam int EV_W   = bdlp_pkg::ev_width(BUTTON_COUNT);
    localparam int PM_LSB = EV_W;
    localparam int ANY_B  = EV_W + BUTTON_COUNT;
    localparam int SEL_B  = ANY_B + 1;
    localparam int HOLD_L = SEL_B + 1;

    logic [EV_W-1:0]                 ev;
    logic [BUTTON_COUNT-1:0]         pm;
    logic [bdlp_pkg::TIME_W-1:0]     hold;

    assign ev   = m_axis_tdata[EV_W-1:0];
    assign pm   = m_axis_tdata[PM_LSB +: BUTTON_COUNT];
    assign hold = m_axis_tdata[HOLD_L +: bdlp_pkg::TIME_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled while the result side can move");

    a_any: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[ANY_B] == (pm != '0))
        else $error("any_pressed disagrees with pressed_mask");

    a_select: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[SEL_B] == pm[BUTTON_COUNT-1]
                          && (m_axis_tdata[SEL_B] || hold == '0))
        else $error("select fields inconsistent");

    a_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ev <= EV_W'(2 * BUTTON_COUNT))
        else $error("event code out of range");

endmodule

bind button_debounce_long_press bdlp_port_checker #(.BUTTON_COUNT(BUTTON_COUNT))
    u_bdlp_checker (.*);

/* test/bdlp_checker.sv */
`timescale 1ns / 100ps
// Result checker for button_debounce_long_press: watches the poll, result and register
// channels, predicts every result word and compares it field by field.
// Depends on bdlp_pkg.

module bdlp_checker #(
    parameter int BUTTON_COUNT = bdlp_pkg::BUTTON_COUNT_DEF,
    parameter int IN_W  = bdlp_pkg::byte_round(bdlp_pkg::in_raw_width(BUTTON_COUNT)),
    parameter int OUT_W = bdlp_pkg::byte_round(bdlp_pkg::out_raw_width(BUTTON_COUNT))
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // now_ms[31:0], raw_levels, clear_combo
    input  logic [IN_W-1:0]                s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // event_code, pressed_mask, any_pressed, select_held, select_hold_ms, combo_fired
    input  logic [OUT_W-1:0]               m_axis_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdlp_pkg::CFG_W-1:0]     cfg_data,
    output int                             fail_count,
    output int                             pending
);

    localparam int TW   = bdlp_pkg::TIME_W;
    localparam int EV_W = bdlp_pkg::ev_width(BUTTON_COUNT);
    localparam int SEL  = BUTTON_COUNT - 1;

    typedef struct packed {
        logic                    combo_fired;
        logic [TW-1:0]           select_hold_ms;
        logic                    select_held;
        logic                    any_pressed;
        logic [BUTTON_COUNT-1:0] pressed_mask;
        logic [EV_W-1:0]         event_code;
    } poll_result_t;

    bdlp_pkg::cfg_t          thresholds;
    logic [BUTTON_COUNT-1:0] last_raw;
    logic [BUTTON_COUNT-1:0] level;
    logic [TW-1:0]           change_ms [BUTTON_COUNT];
    logic [TW-1:0]           start_ms [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] long_done;
    logic [TW-1:0]           combo_start_ms;
    logic                    combo_done;

    poll_result_t expected_q [$];
    poll_result_t want_res;
    poll_result_t got_res;
    int           mismatches  = 0;
    int           outstanding = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    task automatic report_mismatch(input string what, input logic [TW-1:0] got,
                                   input logic [TW-1:0] want);
        $display("mismatch at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic debounce_poll(input logic [TW-1:0] now, input logic [BUTTON_COUNT-1:0] raw,
                                 input logic clr, output poll_result_t res);
        logic [EV_W-1:0]         evt;
        logic [BUTTON_COUNT-1:0] pressed;
        logic [TW-1:0]           elapsed;
        logic [TW-1:0]           hold;
        logic                    fired;
        evt   = '0;
        hold  = '0;
        fired = 1'b0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            if (raw[i] != last_raw[i])
                change_ms[i] = now;
            elapsed = now - change_ms[i];
            if (elapsed > TW'(thresholds.debounce_ms)) begin
                if (raw[i] != level[i]) begin
                    level[i] = raw[i];
                    if (!raw[i]) begin
                        start_ms[i]  = now;
                        long_done[i] = 1'b0;
                    end else begin
                        if (!long_done[i])
                            evt = EV_W'(i + 1);
                        start_ms[i] = '0;
                    end
                end
                elapsed = now - start_ms[i];
                if (!level[i] && !long_done[i] && start_ms[i] != '0 &&
                    elapsed >= TW'(thresholds.long_press_ms)) begin
                    long_done[i] = 1'b1;
                    evt = EV_W'(BUTTON_COUNT + i + 1);
                end
            end
            last_raw[i] = raw[i];
        end

        pressed = ~level;
        if (clr) begin
            combo_start_ms = '0;
            combo_done     = 1'b0;
        end
        if (pressed[bdlp_pkg::UP_IDX] && pressed[bdlp_pkg::DOWN_IDX]) begin
            if (combo_start_ms == '0)
                combo_start_ms = now;
            elapsed = now - combo_start_ms;
            if (!combo_done && elapsed >= TW'(thresholds.combo_hold_ms)) begin
                combo_done = 1'b1;
                fired      = 1'b1;
            end
        end else begin
            combo_start_ms = '0;
            combo_done     = 1'b0;
        end
        if (pressed[SEL] && start_ms[SEL] != '0)
            hold = now - start_ms[SEL];

        res.event_code     = evt;
        res.pressed_mask   = pressed;
        res.any_pressed    = |pressed;
        res.select_held    = pressed[SEL];
        res.select_hold_ms = hold;
        res.combo_fired    = fired;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            thresholds.debounce_ms   = bdlp_pkg::DEBOUNCE_RST;
            thresholds.long_press_ms = bdlp_pkg::LONG_RST;
            thresholds.combo_hold_ms = bdlp_pkg::COMBO_RST;
            last_raw       = '1;
            level          = '1;
            long_done      = '0;
            combo_start_ms = '0;
            combo_done     = 1'b0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                change_ms[i] = '0;
                start_ms[i]  = '0;
            end
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bdlp_pkg::CFG_DEBOUNCE: thresholds.debounce_ms   = cfg_data;
                    bdlp_pkg::CFG_LONG:     thresholds.long_press_ms = cfg_data;
                    bdlp_pkg::CFG_COMBO:    thresholds.combo_hold_ms = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                debounce_poll(s_axis_tdata[TW-1:0], s_axis_tdata[TW +: BUTTON_COUNT],
                              s_axis_tdata[TW + BUTTON_COUNT], want_res);
                expected_q.push_back(want_res);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_res = m_axis_tdata[$bits(poll_result_t)-1:0];
                if (expected_q.size() == 0) begin
                    report_mismatch("result word with nothing pending, event_code",
                                    TW'(got_res.event_code), '0);
                end else begin
                    want_res = expected_q.pop_front();
                    if (got_res.event_code != want_res.event_code)
                        report_mismatch("event_code", TW'(got_res.event_code),
                                        TW'(want_res.event_code));
                    if (got_res.pressed_mask != want_res.pressed_mask)
                        report_mismatch("pressed_mask", TW'(got_res.pressed_mask),
                                        TW'(want_res.pressed_mask));
                    if (got_res.any_pressed != want_res.any_pressed)
                        report_mismatch("any_pressed", TW'(got_res.any_pressed),
                                        TW'(want_res.any_pressed));
                    if (got_res.select_held != want_res.select_held)
                        report_mismatch("select_held", TW'(got_res.select_held),
                                        TW'(want_res.select_held));
                    if (got_res.select_hold_ms != want_res.select_hold_ms)
                        report_mismatch("select_hold_ms", got_res.select_hold_ms,
                                        want_res.select_hold_ms);
                    if (got_res.combo_fired != want_res.combo_fired)
                        report_mismatch("combo_fired", TW'(got_res.combo_fired),
                                        TW'(want_res.combo_fired));
                end
            end
        end
        outstanding <= expected_q.size();
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Top of the button_debounce_long_press testbench: clock, reset, poll and register
// stimulus, result back-pressure and the verdict. Depends on bdlp_pkg and bdlp_checker.

module testbench;

    localparam int BUTTONS      = bdlp_pkg::BUTTON_COUNT_DEF;
    localparam int TW           = bdlp_pkg::TIME_W;
    localparam int CW           = bdlp_pkg::CFG_W;
    localparam int IW           = bdlp_pkg::CFG_IDX_W;
    localparam int IN_W         = bdlp_pkg::byte_round(bdlp_pkg::in_raw_width(BUTTONS));
    localparam int OUT_W        = bdlp_pkg::byte_round(bdlp_pkg::out_raw_width(BUTTONS));
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 6;
    localparam int RANDOM_POLLS = 305;
    localparam int STALL_AFTER  = 150;
    localparam int STALL_CYCLES = 400;

    localparam logic [IW-1:0] CFG_UNUSED = 2'd3;

    localparam logic [CW-1:0] PHASE_DEBOUNCE [PHASES] = '{16'd50, 16'd0, 16'd65535,
                                                          16'd5, 16'd0, 16'd200};
    localparam logic [CW-1:0] PHASE_LONG [PHASES]     = '{16'd1000, 16'd0, 16'd65535,
                                                          16'd40, 16'd1, 16'd3000};
    localparam logic [CW-1:0] PHASE_COMBO [PHASES]    = '{16'd3000, 16'd0, 16'd65535,
                                                          16'd100, 16'd65535, 16'd500};

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [IW-1:0]        cfg_index     = '0;
    logic [CW-1:0]        cfg_data      = '0;

    int                   fail_count;
    int                   pending;
    int                   cycles   = 0;
    bit                   calm     = 1'b0;
    int                   step_max = 2;
    logic [TW-1:0]        clock_ms = '0;
    logic [BUTTONS-1:0]   held     = '0;

    button_debounce_long_press #(
        .BUTTON_COUNT(BUTTONS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bdlp_checker #(
        .BUTTON_COUNT(BUTTONS)
    ) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, calm stretches, and one long hold-off
    initial begin
        int hold_left;
        int results_seen;
        bit pressure_done;
        int r;
        hold_left     = 0;
        results_seen  = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready)
                results_seen++;
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (!pressure_done && results_seen >= STALL_AFTER) begin
                pressure_done = 1'b1;
                hold_left     = STALL_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_axis_tready <= 1'b1;
                end else if (r < 95) begin
                    m_axis_tready <= 1'b0;
                    hold_left = $urandom_range(0, 3);
                end else begin
                    m_axis_tready <= 1'b0;
                    hold_left = $urandom_range(20, 60);
                end
            end
        end
    end

    task automatic send_poll(input logic [TW-1:0] now, input logic [BUTTONS-1:0] raw,
                             input logic clr);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({clr, raw, now});
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_thresholds(input logic [CW-1:0] db, input logic [CW-1:0] lp,
                                   input logic [CW-1:0] ch, input bit spare);
        logic [IW-1:0] idx [4];
        logic [CW-1:0] val [4];
        int            n;
        idx = '{bdlp_pkg::CFG_DEBOUNCE, bdlp_pkg::CFG_LONG, bdlp_pkg::CFG_COMBO, CFG_UNUSED};
        val = '{db, lp, ch, CW'($urandom)};
        n   = spare ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_polls(input int count);
        int                 r;
        int                 b;
        logic [BUTTONS-1:0] raw;
        logic               clr;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r >= 9)
                clock_ms = clock_ms + $urandom_range(1, step_max);
            else if (r >= 7)
                clock_ms = $urandom;
            else if (r == 6)
                clock_ms = $urandom_range(0, 1) ? '0
                                                : 32'hFFFF_FFFF - $urandom_range(0, step_max);
            else if (r >= 3)
                clock_ms = clock_ms - $urandom_range(1, step_max);
            for (int k = 0; k < BUTTONS; k++) begin
                if (held[k] ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 7) == 0))
                    held[k] = ~held[k];
            end
            if ($urandom_range(0, 39) == 0) begin
                held[bdlp_pkg::UP_IDX]   = 1'b1;
                held[bdlp_pkg::DOWN_IDX] = 1'b1;
            end
            raw = ~held;
            if ($urandom_range(0, 19) == 0) begin
                b = $urandom_range(0, BUTTONS - 1);
                raw[b] = ~raw[b];
            end
            clr = ($urandom_range(0, 15) == 0);
            send_poll(clock_ms, raw, clr);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset thresholds: press accepted at time zero, combo restart, clear, release
        send_poll(32'd0,           5'h1F, 1'b0);
        send_poll(32'hFFFF_FF00,   5'h00, 1'b0);
        send_poll(32'd0,           5'h00, 1'b0);
        send_poll(32'd2000,        5'h00, 1'b0);
        send_poll(32'd5000,        5'h00, 1'b0);
        send_poll(32'd5001,        5'h00, 1'b1);
        send_poll(32'd9000,        5'h00, 1'b0);
        send_poll(32'd9010,        5'h1F, 1'b0);
        send_poll(32'd9040,        5'h1F, 1'b0);
        send_poll(32'd9061,        5'h1F, 1'b0);
        send_poll(32'd10000,       5'h0B, 1'b0);
        send_poll(32'd10051,       5'h0B, 1'b0);
        send_poll(32'd11051,       5'h0B, 1'b0);
        send_poll(32'd11060,       5'h1B, 1'b0);
        send_poll(32'd11070,       5'h0B, 1'b0);
        send_poll(32'd11200,       5'h1F, 1'b0);
        send_poll(32'd11300,       5'h1F, 1'b0);
        send_poll(32'hFFFF_FFFF,   5'h1F, 1'b0);
        send_poll(32'h0000_0100,   5'h1C, 1'b1);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                load_thresholds(PHASE_DEBOUNCE[phase], PHASE_LONG[phase], PHASE_COMBO[phase],
                                phase == 1);
            end
            if (phase == 1) begin
                // zero thresholds: same timestamp never passes, long fires on acceptance
                send_poll(32'd20000, 5'h1E, 1'b0);
                send_poll(32'd20000, 5'h1E, 1'b0);
                send_poll(32'd20001, 5'h1E, 1'b0);
                send_poll(32'd20001, 5'h1C, 1'b0);
                send_poll(32'd20002, 5'h1C, 1'b0);
                send_poll(32'd19000, 5'h1F, 1'b0);
            end
            calm     = (phase == 3);
            step_max = ((PHASE_DEBOUNCE[phase] > PHASE_LONG[phase]) ?
                        int'(PHASE_DEBOUNCE[phase]) : int'(PHASE_LONG[phase])) / 4 + 2;
            random_polls(RANDOM_POLLS);
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
